/* sv/extent_free_list_block_allocator_core_assert.svh */
// Assertion macros shared by the extent free-list allocator modules.
`ifndef EXTENT_FREE_LIST_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define EXTENT_FREE_LIST_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define EFL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define EFL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`endif

/* sv/efl_pkg.sv */
// Shared constants, types and codes for the extent free-list allocator.
package efl_pkg;

    localparam int NUM_BLOCKS = 1024;
    localparam int BLK_W      = $clog2(NUM_BLOCKS);
    localparam int TB_W       = BLK_W + 1;

    localparam logic [BLK_W-1:0] BLK_LAST  = BLK_W'(NUM_BLOCKS - 1);
    localparam logic [BLK_W-1:0] FREE_MAX  = BLK_W'(NUM_BLOCKS - 1);
    localparam logic [TB_W-1:0]  TB_MIN    = TB_W'(2);
    localparam logic [TB_W-1:0]  TB_MAX    = TB_W'(NUM_BLOCKS);
    localparam logic [TB_W-1:0]  TB_RESET  = TB_W'(1024);

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_FORMAT = 2'd2;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_NONE = 1'b1;

    typedef struct packed {
        logic [BLK_W-1:0] len;
        logic [BLK_W-1:0] next;
    } rec_t;

    typedef struct packed {
        logic             we;
        logic [BLK_W-1:0] waddr;
        rec_t             wdata;
        logic             re;
        logic [BLK_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic [BLK_W-1:0] granted_block;
        logic             status;
        logic [BLK_W-1:0] free_count;
    } res_t;

endpackage

/* sv/efl_extent_ram.sv */
// Extent record memory: one write port, one read port with registered data.
module efl_extent_ram
    import efl_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output rec_t     rdata
);

    rec_t mem [NUM_BLOCKS];
    rec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/efl_engine.sv */
// Operation sequencer: head pointer, free counter, size register and record updates.
module efl_engine
    import efl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       op,
    input  logic [BLK_W-1:0] block,
    input  logic             cfg_we,
    input  logic [TB_W-1:0]  cfg_wdata,
    output mem_req_t         mem_req,
    input  rec_t             mem_rdata,
    input  logic             res_ready,
    output logic             res_load,
    output res_t             res
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic             state_reg, state_next;
    logic [BLK_W-1:0] head_reg, head_next;
    logic [BLK_W-1:0] free_reg, free_next;
    logic [TB_W-1:0]  total_reg;
    logic [1:0]       op_reg;
    logic [BLK_W-1:0] blk_reg;
    logic [TB_W-1:0]  tb_clamped;
    logic [BLK_W-1:0] head_inc;
    logic             in_accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign res_load  = (state_reg == ST_EXEC) && res_ready;

    // Out-of-range sizes are pulled into the legal range.
    always_comb
    begin
        priority if (total_reg < TB_MIN)
        begin
            tb_clamped = TB_MIN;
        end
        else if (total_reg > TB_MAX)
        begin
            tb_clamped = TB_MAX;
        end
        else
        begin
            tb_clamped = total_reg;
        end
    end

    assign head_inc = (head_reg == BLK_LAST) ? '0 : head_reg + BLK_W'(1);

    always_comb
    begin
        state_next        = state_reg;
        head_next         = head_reg;
        free_next         = free_reg;
        mem_req.re        = in_accept;
        mem_req.raddr     = head_reg;
        mem_req.we        = 1'b0;
        mem_req.waddr     = '0;
        mem_req.wdata     = '0;
        res.granted_block = '0;
        res.status        = STATUS_DONE;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                    unique case (op_reg)
                        OP_ALLOC:
                        begin
                            if (free_reg == '0 || head_reg == '0)
                            begin
                                res.status = STATUS_NONE;
                            end
                            else
                            begin
                                res.granted_block = head_reg;
                                free_next         = free_reg - BLK_W'(1);
                                if (mem_rdata.len > BLK_W'(1))
                                begin
                                    // Shrink the head extent; its record moves up a block.
                                    head_next          = head_inc;
                                    mem_req.we         = 1'b1;
                                    mem_req.waddr      = head_inc;
                                    mem_req.wdata.len  = mem_rdata.len - BLK_W'(1);
                                    mem_req.wdata.next = mem_rdata.next;
                                end
                                else
                                begin
                                    head_next = mem_rdata.next;
                                end
                            end
                        end
                        OP_FREE:
                        begin
                            if (blk_reg != '0)
                            begin
                                mem_req.we         = 1'b1;
                                mem_req.waddr      = blk_reg;
                                mem_req.wdata.len  = BLK_W'(1);
                                mem_req.wdata.next = head_reg;
                                head_next          = blk_reg;
                                if (free_reg != FREE_MAX)
                                begin
                                    free_next = free_reg + BLK_W'(1);
                                end
                            end
                        end
                        OP_FORMAT:
                        begin
                            mem_req.we         = 1'b1;
                            mem_req.waddr      = BLK_W'(1);
                            mem_req.wdata.len  = BLK_W'(tb_clamped - TB_W'(1));
                            mem_req.wdata.next = '0;
                            head_next          = BLK_W'(1);
                            free_next          = BLK_W'(tb_clamped - TB_W'(1));
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase

        res.free_count = free_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            free_reg  <= '0;
            total_reg <= TB_RESET;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            free_reg  <= free_next;
            if (cfg_we)
            begin
                total_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg  <= op;
            blk_reg <= block;
        end
    end

`include "extent_free_list_block_allocator_core_assert.svh"

    `EFL_ASSERT_NEXT(a_accept_then_exec, in_accept, !in_ready)
    `EFL_ASSERT_NEXT(a_load_then_idle, res_load, in_ready)
    `EFL_ASSERT_NOW(a_fail_grants_zero, res_load && res.status == STATUS_NONE,
                    res.granted_block == '0 && op_reg == OP_ALLOC)
    `EFL_ASSERT_NEXT(a_format_head, res_load && op_reg == OP_FORMAT,
                     head_reg == BLK_W'(1) && free_reg != '0)
    `EFL_ASSERT_NOW(a_write_only_on_load, mem_req.we, res_load)

endmodule

/* sv/efl_result_reg.sv */
// Output register holding one result until the receiver takes it.
module efl_result_reg
    import efl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  res_t             res,
    output logic             load_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [BLK_W-1:0] granted_block,
    output logic             status,
    output logic [BLK_W-1:0] free_count
);

    logic valid_reg;
    res_t data_reg;

    assign load_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign out_valid     = valid_reg;
    assign granted_block = data_reg.granted_block;
    assign status        = data_reg.status;
    assign free_count    = data_reg.free_count;

`include "extent_free_list_block_allocator_core_assert.svh"

    `EFL_ASSERT_NOW(a_load_has_room, load, load_ready)
    `EFL_ASSERT_NEXT(a_held_while_stalled, valid_reg && !out_ready && !load,
                     valid_reg && $stable(data_reg))
    `EFL_ASSERT_NEXT(a_load_sets_valid, load, valid_reg)

endmodule

/* sv/extent_free_list_block_allocator_core.sv */
// Top level of the extent free-list block allocator.
//
// Usage: a request transfer on in_valid/in_ready carries op (allocate, free,
// format) and block. Each request yields exactly one result transfer on
// out_valid/out_ready with granted_block, status and free_count.
// The accept cycle issues a read of the head extent record; the update state
// then applies the update once the output register has room and writes at
// most one record back into the single-port-write extent memory. A new
// request is accepted only once the previous one has left the update state;
// the result is loaded from there into the output register.
// If the receiver stalls, the finished result sits in the output register and
// one further request is still accepted; that request then waits in its
// update cycle until the output register frees up.
// Reset clears head pointer and free count to zero and sets total_blocks to 1024.
// The extent memory is not cleared; a format request builds the free list. The
// user writes total_blocks via cfg_we/cfg_wdata only while idle; nothing checks it.
module extent_free_list_block_allocator_core
    import efl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       op,
    input  logic [BLK_W-1:0] block,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [BLK_W-1:0] granted_block,
    output logic             status,
    output logic [BLK_W-1:0] free_count,
    input  logic             cfg_we,
    input  logic [TB_W-1:0]  cfg_wdata
);

    mem_req_t mem_req;
    rec_t     mem_rdata;
    res_t     res;
    logic     res_load;
    logic     res_ready;

    // Extent records, one per block, addressed by the block index.
    efl_extent_ram u_ram (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // Read-modify-write sequencer that owns the head pointer and free count.
    efl_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .block     (block),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res_ready (res_ready),
        .res_load  (res_load),
        .res       (res)
    );

    // Result register decoupling the engine from the receiver.
    efl_result_reg u_result (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (res_load),
        .res           (res),
        .load_ready    (res_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .granted_block (granted_block),
        .status        (status),
        .free_count    (free_count)
    );

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the extent free-list block allocator core.
module tb;
    import efl_pkg::*;

    // Opcode 3 is not defined by the package; the block must treat it as a no-op.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 60;
    localparam int SEGMENT_ITEMS  = 110;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [1:0]       op;
        logic [BLK_W-1:0] blk;
    } req_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [1:0]       op = OP_ALLOC;
    logic [BLK_W-1:0] block = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [BLK_W-1:0] granted_block;
    logic             status;
    logic [BLK_W-1:0] free_count;
    logic             cfg_we = 1'b0;
    logic [TB_W-1:0]  cfg_wdata = '0;

    // Requests waiting to be offered, and the results they must produce, in order.
    req_t request_q[$];
    res_t pending_results[$];

    // Blocks handed out and not yet returned. Random frees mostly draw from here
    // so that the list keeps a realistic shape.
    logic [BLK_W-1:0] held_blocks[$];

    // Shadow of the allocator state: extent records, which records have been
    // written, head pointer, free counter and the volume size register.
    rec_t             ext_rec[NUM_BLOCKS];
    bit               rec_written[NUM_BLOCKS];
    logic [BLK_W-1:0] head_blk = '0;
    logic [BLK_W-1:0] free_left = '0;
    logic [TB_W-1:0]  vol_blocks = TB_RESET;

    // Idle percentages for each side, switched between test segments.
    int send_idle_pct = 14;
    int recv_idle_pct = 78;

    // A long receiver hold-off is requested by bumping hold_req.
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    int mismatches = 0;
    int quiet_cycles = 0;

    extent_free_list_block_allocator_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .block         (block),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .granted_block (granted_block),
        .status        (status),
        .free_count    (free_count),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #4 clk = ~clk;

    // Computes the result of one request and advances the shadow state.
    function automatic res_t allocator_result(input logic [1:0] code,
                                              input logic [BLK_W-1:0] b);
        res_t            r;
        rec_t            cur;
        logic [TB_W-1:0] eff;
        r = '0;
        r.status = STATUS_DONE;
        case (code)
            OP_ALLOC:
            begin
                if (free_left == 0 || head_blk == 0)
                begin
                    r.status = STATUS_NONE;
                end
                else
                begin
                    cur = ext_rec[head_blk];
                    r.granted_block = head_blk;
                    if (cur.len > 1)
                    begin
                        // The head extent shrinks: its record moves one block up,
                        // wrapping at the end of the store.
                        head_blk = head_blk + 1'b1;
                        cur.len = cur.len - 1'b1;
                        ext_rec[head_blk] = cur;
                        rec_written[head_blk] = 1'b1;
                    end
                    else
                    begin
                        head_blk = cur.next;
                    end
                    free_left = free_left - 1'b1;
                end
            end
            OP_FREE:
            begin
                // Block zero holds the superblock and is never pushed.
                if (b != 0)
                begin
                    ext_rec[b].len = BLK_W'(1);
                    ext_rec[b].next = head_blk;
                    rec_written[b] = 1'b1;
                    head_blk = b;
                    if (free_left != FREE_MAX)
                        free_left = free_left + 1'b1;
                end
            end
            OP_FORMAT:
            begin
                // Out-of-range volume sizes are clamped before use.
                eff = vol_blocks;
                if (eff < TB_MIN)
                    eff = TB_MIN;
                if (eff > TB_MAX)
                    eff = TB_MAX;
                head_blk = BLK_W'(1);
                free_left = BLK_W'(eff - 1);
                ext_rec[1].len = BLK_W'(eff - 1);
                ext_rec[1].next = '0;
                rec_written[1] = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.free_count = free_left;
        return r;
    endfunction

    // Queues one request together with its expected result.
    task automatic push_req(input logic [1:0] code, input logic [BLK_W-1:0] b);
        req_t q;
        res_t r;
        q.op = code;
        q.blk = b;
        r = allocator_result(code, b);
        request_q.push_back(q);
        pending_results.push_back(r);
        if (code == OP_ALLOC && r.status == STATUS_DONE)
            held_blocks.push_back(r.granted_block);
        else if (code == OP_FORMAT)
            held_blocks.delete();
    endtask

    // Draws one random request. Most frees return a block that was handed out;
    // the rest hit block zero or any index, which covers double frees and blocks
    // beyond the volume.
    task automatic push_random();
        int               pick;
        int               idx;
        logic [1:0]       code;
        logic [BLK_W-1:0] b;
        pick = $urandom_range(99);
        b = BLK_W'($urandom_range(NUM_BLOCKS - 1));
        if (pick < 4)
            code = OP_FORMAT;
        else if (pick < 8)
            code = OP_UNUSED;
        else if (pick < 52)
            code = OP_ALLOC;
        else
        begin
            code = OP_FREE;
            if (held_blocks.size() != 0 && $urandom_range(9) < 7)
            begin
                idx = $urandom_range(held_blocks.size() - 1);
                b = held_blocks[idx];
                held_blocks.delete(idx);
            end
            else if ($urandom_range(4) == 0)
            begin
                b = '0;
            end
        end
        // An allocation must never read a record that was never written.
        if (code == OP_ALLOC && free_left != 0 && head_blk != 0 && !rec_written[head_blk])
            code = OP_FORMAT;
        push_req(code, b);
    endtask

    // Waits until every queued request has been sent and every result has come
    // back, then lets the pipeline settle.
    task automatic drain();
        while (request_q.size() != 0 || in_valid || pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Writes the volume size register while the block is idle.
    task automatic set_volume(input logic [TB_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        vol_blocks = v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Request driver: a new request is presented only once the previous one has
    // been transferred, and the sender idles at random between requests.
    always @(posedge clk or negedge rst_n)
    begin
        req_t q;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            op <= OP_ALLOC;
            block <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                q = request_q.pop_front();
                in_valid <= 1'b1;
                op <= q.op;
                block <= q.blk;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request that lets
    // the block fill up and push back on its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req != hold_seen)
        begin
            out_ready <= 1'b0;
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result checker: each result transfer is compared with the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result with nothing expected: granted=%0d status=%0d free=%0d",
                             $time, granted_block, status, free_count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (granted_block !== want.granted_block || status !== want.status ||
                    free_count !== want.free_count)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: expected granted=%0d status=%0d free=%0d, got granted=%0d status=%0d free=%0d",
                                 $time, want.granted_block, want.status, want.free_count,
                                 granted_block, status, free_count);
                end
            end
        end
    end

    // Watchdog: the run is stuck when no transfer happens on either side for
    // far longer than any legal stall.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("extent_free_list_block_allocator_core verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [TB_W-1:0] vols[9];
        int              seg;
        vols = '{TB_W'(2), TB_W'(1024), TB_W'(0), TB_W'(5), TB_W'(2047),
                 TB_W'(1023), TB_W'(1025), TB_W'(3), TB_W'(0)};
        vols[8] = TB_W'($urandom_range(6, 64));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, volume size still at its reset value.
        push_req(OP_ALLOC, '0);             // nothing free yet
        push_req(OP_UNUSED, '0);            // unused opcode
        push_req(OP_FREE, '0);              // freeing the superblock is ignored
        push_req(OP_FREE, BLK_LAST);        // highest block index
        push_req(OP_ALLOC, BLK_LAST);       // takes it back, list empty again
        push_req(OP_FORMAT, '0);            // full volume, counter at its maximum
        push_req(OP_FREE, BLK_W'(512));     // counter saturates
        push_req(OP_ALLOC, '0);
        push_req(OP_ALLOC, '0);
        push_req(OP_FREE, BLK_W'(2));       // double free of the current head
        push_req(OP_ALLOC, '0);
        push_req(OP_FREE, BLK_W'(341));
        push_req(OP_FREE, BLK_W'(682));
        push_req(OP_ALLOC, '0);
        push_req(OP_ALLOC, '0);
        push_req(OP_UNUSED, BLK_LAST);
        drain();

        // Tiny volume: exhaust it, then free a block beyond its end.
        set_volume(TB_W'(3));
        push_req(OP_FORMAT, BLK_LAST);
        push_req(OP_ALLOC, '0);
        push_req(OP_ALLOC, '0);
        push_req(OP_ALLOC, '0);             // nothing left
        push_req(OP_FREE, BLK_W'(900));
        push_req(OP_ALLOC, '0);
        drain();

        // Random part: three segments per idling mode, each with its own volume
        // size. Every segment starts from a fresh format so that most traffic
        // runs on a well-formed list.
        for (seg = 0; seg < 9; seg++)
        begin
            if (seg < 3)
            begin
                send_idle_pct = 14;
                recv_idle_pct = 78;
            end
            else if (seg < 6)
            begin
                send_idle_pct = 78;
                recv_idle_pct = 14;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_volume(vols[seg]);
            push_req(OP_FORMAT, BLK_W'($urandom_range(NUM_BLOCKS - 1)));
            repeat (SEGMENT_ITEMS) push_random();
            // Back-pressure: the receiver stops while the sender keeps offering.
            if (seg == 0 || seg == 6)
                hold_req = hold_req + 1;
            drain();
        end

        repeat (8) @(negedge clk);
        if (pending_results.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("extent_free_list_block_allocator_core verification clean");
        else
            $display("extent_free_list_block_allocator_core verification failed");
        $finish;
    end

endmodule

/* extent_free_list_block_allocator_core.f */
+incdir+sv
sv/efl_pkg.sv
sv/efl_extent_ram.sv
sv/efl_engine.sv
sv/efl_result_reg.sv
sv/extent_free_list_block_allocator_core.sv
bench/tb.sv
